>>> design/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types for the chunked body decoder
// Input opcodes, result kinds, error codes, the classified item that moves
// from the front end to the decoder core, and the queue depth between them.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int QDEPTH = 2;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [31:0] MAX_CHUNK_RESET = 32'd8388608;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_RESTART = 2'd2,
        OP_RSVD    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_SIZE       = 2'd0,
        ERR_LARGE      = 2'd1,
        ERR_TERM       = 2'd2,
        ERR_INCOMPLETE = 2'd3
    } err_t;

    // classified input item
    typedef struct packed {
        opcode_t     op;
        logic [7:0]  data;
        logic        is_cr;
        logic        is_lf;
        logic        is_semi;
        logic        is_hex;
        logic [3:0]  hex_val;
    } item_t;

endpackage

>>> design/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front: input classifier
// Decodes the opcode and tags each byte as CR, LF, ';' or hex digit, with the
// digit's value, so the decoder core needs no character compares.
// ----------------------------------------------------------------------------
module hcbd_front (
    input  logic [1:0]     opcode,
    input  logic [7:0]     byte_value,
    output hcbd_pkg::item_t item
);
    import hcbd_pkg::*;

    always_comb begin
        item.op      = opcode_t'(opcode);
        item.data    = byte_value;
        item.is_cr   = (byte_value == CH_CR);
        item.is_lf   = (byte_value == CH_LF);
        item.is_semi = (byte_value == CH_SEMI);
        item.is_hex  = 1'b0;
        item.hex_val = 4'd0;
        if (byte_value >= 8'h30 && byte_value <= 8'h39) begin
            item.is_hex  = 1'b1;
            item.hex_val = byte_value[3:0];
        end else if ((byte_value >= 8'h61 && byte_value <= 8'h66) ||
                     (byte_value >= 8'h41 && byte_value <= 8'h46)) begin
            // a..f and A..F share the low nibble 1..6
            item.is_hex  = 1'b1;
            item.hex_val = byte_value[3:0] + 4'd9;
        end
    end

endmodule

>>> design/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue: short item queue
// Holds classified items between the front end and the decoder core so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module hcbd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hcbd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output hcbd_pkg::item_t pop_item
);
    import hcbd_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    item_t         mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back: chunked framing decoder core
// Runs the size line / data / terminator sequence on classified items and
// drives the registered result stage.
// ----------------------------------------------------------------------------
module hcbd_back #(
    parameter int MAX_SIZE_DIGITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [31:0]     max_chunk_size,
    input  logic            item_valid,
    input  hcbd_pkg::item_t item,
    output logic            item_take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_data,
    output logic [1:0]      out_err
);
    import hcbd_pkg::*;

    localparam int DCW = $clog2(MAX_SIZE_DIGITS + 2);
    localparam logic [DCW-1:0] DMAX = DCW'(MAX_SIZE_DIGITS);

    typedef enum logic [5:0] {
        PH_SIZE  = 6'b000001,
        PH_DATA  = 6'b000010,
        PH_TERM1 = 6'b000100,
        PH_TERM2 = 6'b001000,
        PH_DONE  = 6'b010000,
        PH_FAIL  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_BAD   = 2'd1,
        PEND_LARGE = 2'd2
    } pend_t;

    phase_t         phase_reg, phase_next;
    logic [35:0]    acc_reg, acc_next;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic           ext_reg, ext_next;
    logic           cr_reg, cr_next;
    pend_t          pend_reg, pend_next;
    logic [31:0]    rem_reg, rem_next;

    logic           out_valid_reg, out_valid_next;
    kind_t          out_kind_reg, out_kind_next;
    logic [7:0]     out_data_reg, out_data_next;
    err_t           out_err_reg, out_err_next;

    logic [35:0]    acc_shift;
    logic           acc_over;

    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;
    assign out_err   = out_err_reg;

    assign acc_shift = {acc_reg[31:0], item.hex_val};
    assign acc_over  = (acc_shift > {4'd0, max_chunk_size});

    always_comb begin
        logic           emit;
        logic           e1;
        logic [DCW-1:0] c1;
        pend_t          p1;

        emit          = 1'b0;
        e1            = ext_reg;
        c1            = cnt_reg;
        p1            = pend_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ext_next      = ext_reg;
        cr_next       = cr_reg;
        pend_next     = pend_reg;
        rem_next      = rem_reg;
        out_kind_next = out_kind_reg;
        out_data_next = out_data_reg;
        out_err_next  = out_err_reg;

        if (item_take) begin
            priority if (item.op == OP_RESTART) begin
                phase_next = PH_SIZE;
                acc_next   = '0;
                cnt_next   = '0;
                ext_next   = 1'b0;
                cr_next    = 1'b0;
                pend_next  = PEND_NONE;
                rem_next   = '0;
            end else if (item.op == OP_RSVD || phase_reg == PH_DONE ||
                         phase_reg == PH_FAIL) begin
                // ignored
            end else if (item.op == OP_CLOSE) begin
                phase_next    = PH_FAIL;
                emit          = 1'b1;
                out_kind_next = KIND_ERROR;
                out_data_next = 8'd0;
                out_err_next  = ERR_INCOMPLETE;
            end else begin
                unique case (phase_reg)
                    PH_SIZE: begin
                        if (cr_reg && item.is_lf) begin
                            cr_next = 1'b0;
                            emit    = 1'b1;
                            out_kind_next = KIND_ERROR;
                            out_data_next = 8'd0;
                            if (cnt_reg == '0 || cnt_reg > DMAX ||
                                pend_reg == PEND_BAD) begin
                                phase_next   = PH_FAIL;
                                out_err_next = ERR_SIZE;
                            end else if (pend_reg == PEND_LARGE) begin
                                phase_next   = PH_FAIL;
                                out_err_next = ERR_LARGE;
                            end else begin
                                emit         = 1'b0;
                                out_kind_next = out_kind_reg;
                                out_data_next = out_data_reg;
                                rem_next     = acc_reg[31:0];
                                phase_next   = (acc_reg[31:0] != '0) ? PH_DATA : PH_TERM1;
                            end
                        end else begin
                            // a held CR that is not followed by LF counts as a
                            // line character; it is never a hex digit
                            if (cr_reg && !e1) begin
                                if (c1 <= DMAX) c1 = c1 + 1'b1;
                                if (c1 <= DMAX && p1 == PEND_NONE) p1 = PEND_BAD;
                            end
                            if (item.is_cr) begin
                                cr_next = 1'b1;
                            end else begin
                                cr_next = 1'b0;
                                if (!e1) begin
                                    if (item.is_semi) begin
                                        e1 = 1'b1;
                                    end else begin
                                        if (c1 <= DMAX) c1 = c1 + 1'b1;
                                        if (c1 <= DMAX && p1 == PEND_NONE) begin
                                            if (!item.is_hex) begin
                                                p1 = PEND_BAD;
                                            end else begin
                                                acc_next = acc_shift;
                                                if (acc_over) p1 = PEND_LARGE;
                                            end
                                        end
                                    end
                                end
                            end
                            ext_next  = e1;
                            cnt_next  = c1;
                            pend_next = p1;
                        end
                    end
                    PH_DATA: begin
                        rem_next = rem_reg - 1'b1;
                        if (rem_reg == 32'd1) phase_next = PH_TERM1;
                        emit          = 1'b1;
                        out_kind_next = KIND_DATA;
                        out_data_next = item.data;
                        out_err_next  = ERR_SIZE;
                    end
                    PH_TERM1: begin
                        cr_next    = item.is_cr;
                        phase_next = PH_TERM2;
                    end
                    PH_TERM2: begin
                        if (!(cr_reg && item.is_lf)) begin
                            phase_next    = PH_FAIL;
                            emit          = 1'b1;
                            out_kind_next = KIND_ERROR;
                            out_data_next = 8'd0;
                            out_err_next  = ERR_TERM;
                        end else begin
                            cr_next = 1'b0;
                            if (acc_reg == '0) begin
                                phase_next    = PH_DONE;
                                emit          = 1'b1;
                                out_kind_next = KIND_DONE;
                                out_data_next = 8'd0;
                                out_err_next  = ERR_SIZE;
                            end else begin
                                phase_next = PH_SIZE;
                                acc_next   = '0;
                                cnt_next   = '0;
                                ext_next   = 1'b0;
                                pend_next  = PEND_NONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            ext_reg       <= 1'b0;
            cr_reg        <= 1'b0;
            pend_reg      <= PEND_NONE;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            ext_reg       <= ext_next;
            cr_reg        <= cr_next;
            pend_reg      <= pend_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

endmodule

>>> design/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder
// Strips chunked framing from a message body streamed one byte per transfer.
//
// Input stream (s_*): s_tuser carries the opcode (byte, peer close, restart),
// s_tdata the body byte. Output stream (m_*): m_tuser carries the result kind
// (data byte, body complete, error), m_tdata the data byte and error code.
// Size lines, chunk extensions and CR LF terminators produce no output.
// cfg_* writes the per-chunk size limit; write it only while idle.
//
// Throughput is one item per cycle while the output is not stalled. An accepted
// item is written into the queue, then taken by the decoder core once the
// output stage is free, and its result, if any, is registered in the output
// stage. The front end feeds a two-entry queue, so input keeps flowing while
// m_tready is low until the queue is full; after that s_tready drops until
// the output drains. Reset clears the queue, the output stage and all decode
// state, and loads the size limit with 8 MiB. A restart opcode clears decode
// state only.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int MAX_SIZE_DIGITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,     // max_chunk_size

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] byte_value
    input  logic [1:0]  s_tuser,      // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [7:0] data_byte, [9:8] err_code
    output logic [1:0]  m_tuser       // [1:0] result_kind
);
    import hcbd_pkg::*;

    logic [31:0] max_chunk_reg;
    item_t       in_item;
    item_t       q_item;
    logic        q_full;
    logic        q_valid;
    logic        back_take;
    logic        s_xfer;
    logic [7:0]  out_data;
    logic [1:0]  out_err;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign s_xfer    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_reg <= MAX_CHUNK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_chunk_reg <= cfg_data;
        end
    end

    hcbd_front u_front (
        .opcode     (s_tuser),
        .byte_value (s_tdata),
        .item       (in_item)
    );

    hcbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_xfer),
        .push_item (in_item),
        .full      (q_full),
        .pop       (back_take),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    hcbd_back #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_chunk_size (max_chunk_reg),
        .item_valid     (q_valid),
        .item           (q_item),
        .item_take      (back_take),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_data       (out_data),
        .out_err        (out_err)
    );

    assign m_tdata = {6'd0, out_err, out_data};

    // a full queue always has an item to offer the core
    a_full_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("queue full but empty");

    // the core never consumes while a result is stuck in the output stage
    a_no_take_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        back_take |-> (!m_tvalid || m_tready))
        else $error("item taken while output stalled");

    // an accepted transfer is visible in the queue on the next cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> q_valid)
        else $error("accepted item lost");

    // body complete is never directly followed by another result
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == KIND_DONE) |=> !m_tvalid)
        else $error("result right after body complete");

endmodule
